FILE: hw/rtl/qte_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tables for the quaternion to euler converter
// no dependencies

package qte_pkg;

  // field widths
  localparam int QW       = 16;
  localparam int AW       = 16;
  localparam int THR_W    = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd16351;

  // atan2 operand width (q.30 values after doubling) and cordic datapath width
  localparam int OPW      = 34;
  localparam int CW       = 38;
  localparam int ACC_W    = 24;
  localparam int LANES    = 3;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_LEN      = 24;

  // square root unit: one result bit per stage
  localparam int SQ_STEPS = 31;
  localparam int RAD_W    = 2 * SQ_STEPS;

  localparam logic signed [OPW-1:0] ONE_Q30   = 34'sd1073741824;
  localparam logic [RAD_W-1:0]      ONE_Q60   = 62'd1 << 60;
  localparam logic signed [ACC_W-1:0] PI_UNITS = 24'sd3294199;
  localparam logic signed [AW-1:0]  HALF_PI_Q12 = 16'sd6434;

  typedef logic signed [ACC_W-1:0] ang_t;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [AW-1:0] angle_x;
    logic signed [AW-1:0] angle_y;
    logic signed [AW-1:0] angle_z;
    logic [1:0]           pole_case;
  } euler_t;

  // one atan2 request: y over x
  typedef struct packed {
    logic signed [OPW-1:0] y;
    logic signed [OPW-1:0] x;
  } vec_t;

  // item state carried from the front end through the square root unit
  typedef struct packed {
    vec_t                  ang_x;
    vec_t                  ang_y;
    logic signed [OPW-1:0] s;
    pole_e                 pole;
  } side_t;

  // atan(2^-i) in units of 2^-20 rad
  function automatic ang_t atan_units(input int i);
    ang_t r;
    case (i)
      0:  r = 24'sd823550;
      1:  r = 24'sd486170;
      2:  r = 24'sd256879;
      3:  r = 24'sd130396;
      4:  r = 24'sd65451;
      5:  r = 24'sd32757;
      6:  r = 24'sd16383;
      7:  r = 24'sd8192;
      8:  r = 24'sd4096;
      9:  r = 24'sd2048;
      10: r = 24'sd1024;
      11: r = 24'sd512;
      12: r = 24'sd256;
      13: r = 24'sd128;
      14: r = 24'sd64;
      15: r = 24'sd32;
      16: r = 24'sd16;
      17: r = 24'sd8;
      18: r = 24'sd4;
      19: r = 24'sd2;
      20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // 2^-20 rad to q4.12 with round half up and saturation
  function automatic logic signed [AW-1:0] to_q12(input logic signed [ACC_W+1:0] a);
    logic signed [ACC_W+1:0] t;
    logic signed [AW-1:0]    r;
    t = (a + 26'sd128) >>> 8;
    if (t > 26'sd32767) begin
      r = 16'sd32767;
    end else if (t < -26'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = t[AW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/quaternion_to_euler.sv
`timescale 1ns / 1ps
// top level of the quaternion to euler converter: threshold register, output stage
// depends on qte_pkg, qte_front, qte_sqrt, qte_cordic

// Converts one unit quaternion (Q1.15) into three Euler angles (Q4.12 radians) and a
// pole flag. The pipeline accepts one item per clock while the output is not stalled and
// returns results in order. It has 4 front-end stages for products and the pole test,
// 31 square root stages, one fold stage and CORDIC_STAGES rotation stages of the atan2
// units, and one output register. A stall on the output fills empty stages first, so
// items keep entering until the pipeline is full. The pole threshold register is
// written through the cfg channel, which is always ready; write it only while no item
// is in flight.

module quaternion_to_euler #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  qte_pkg::quat_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output qte_pkg::euler_t           out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [qte_pkg::THR_W-1:0] cfg_data_i
);

  logic [qte_pkg::THR_W-1:0] thr_q;

  logic                      fr_valid, fr_ready;
  qte_pkg::side_t            fr_side;
  logic [qte_pkg::RAD_W-1:0] fr_rad;

  logic                         sq_valid, sq_ready;
  logic [qte_pkg::SQ_STEPS-1:0] sq_root;
  qte_pkg::side_t               sq_side;

  qte_pkg::vec_t [qte_pkg::LANES-1:0] lanes;
  logic                               co_valid, co_ready;
  qte_pkg::ang_t [qte_pkg::LANES-1:0] co_acc;
  qte_pkg::pole_e                     co_pole;

  logic            out_v_q;
  qte_pkg::euler_t out_q;
  qte_pkg::euler_t out_d;
  logic signed [qte_pkg::ACC_W+1:0] ax;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qte_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  qte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .thr_i       (thr_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_side_o  (fr_side),
    .out_rad_o   (fr_rad)
  );

  qte_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .rad_i       (fr_rad),
    .side_i      (fr_side),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  // lane 0 first angle, lane 1 second angle, lane 2 asin as atan2(s, cos)
  always_comb begin
    lanes[0]   = sq_side.ang_x;
    lanes[1]   = sq_side.ang_y;
    lanes[2].y = sq_side.s;
    lanes[2].x = qte_pkg::OPW'(sq_root);
  end

  qte_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .lanes_i     (lanes),
    .pole_i      (sq_side.pole),
    .out_valid_o (co_valid),
    .out_ready_i (co_ready),
    .acc_o       (co_acc),
    .pole_o      (co_pole)
  );

  // pole selection and conversion to q4.12
  always_comb begin
    ax = (qte_pkg::ACC_W + 2)'($signed(co_acc[0]));
    out_d.pole_case = co_pole;
    case (co_pole)
      qte_pkg::POLE_NORTH: begin
        out_d.angle_x = qte_pkg::to_q12(ax <<< 1);
        out_d.angle_y = '0;
        out_d.angle_z = qte_pkg::HALF_PI_Q12;
      end
      qte_pkg::POLE_SOUTH: begin
        out_d.angle_x = qte_pkg::to_q12(-(ax <<< 1));
        out_d.angle_y = '0;
        out_d.angle_z = -qte_pkg::HALF_PI_Q12;
      end
      default: begin
        out_d.angle_x = qte_pkg::to_q12(ax);
        out_d.angle_y = qte_pkg::to_q12((qte_pkg::ACC_W + 2)'($signed(co_acc[1])));
        out_d.angle_z = qte_pkg::to_q12((qte_pkg::ACC_W + 2)'($signed(co_acc[2])));
      end
    endcase
  end

  // output register
  assign co_ready = ~out_v_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (co_ready) begin
      out_v_q <= co_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (co_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/qte_front.sv
`timescale 1ns / 1ps
// front end: products, pole test, atan2 operands and square root radicand
// depends on qte_pkg

module qte_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  qte_pkg::quat_t               in_data_i,
  input  logic [qte_pkg::THR_W-1:0]    thr_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output qte_pkg::side_t               out_side_o,
  output logic [qte_pkg::RAD_W-1:0]    out_rad_o
);

  localparam int OPW = qte_pkg::OPW;

  logic [3:0] v_q;
  logic [4:0] rdy;

  // stage 1 registers
  logic signed [31:0] p_xy_q, p_zw_q, p_yw_q, p_xz_q, p_yy_q, p_zz_q, p_xw_q, p_yz_q, p_xx_q;
  logic signed [qte_pkg::QW-1:0] w_q, x_q;
  // stage 2 registers
  qte_pkg::side_t side2_q;
  logic [30:0]    mag_q;
  logic           ok2_q;
  // stage 3 registers
  qte_pkg::side_t side3_q;
  logic [61:0]    sq_q;
  logic           ok3_q;
  // stage 4 registers
  qte_pkg::side_t side4_q;
  logic [qte_pkg::RAD_W-1:0] rad_q;

  // stage 2 logic
  logic signed [32:0]    test;
  logic signed [32:0]    thr_s;
  logic                  north, south;
  logic signed [OPW-1:0] d_x, d_y, s_val, mag;
  qte_pkg::side_t        side2_d;

  // ready chain, a stage moves when it is empty or the next one moves
  always_comb begin
    rdy[4] = out_ready_i;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // pole test, operands of the three atan2 units
  always_comb begin
    test  = 33'(p_xy_q) + 33'(p_zw_q);
    thr_s = $signed({3'b000, thr_i, 15'b0});
    north = test > thr_s;
    south = test < -thr_s;
    d_x   = 34'(p_yw_q) - 34'(p_xz_q);
    d_y   = 34'(p_xw_q) - 34'(p_yz_q);
    s_val = 34'(test) <<< 1;
    mag   = s_val[OPW-1] ? -s_val : s_val;

    side2_d.ang_y.y = d_y <<< 1;
    side2_d.ang_y.x = qte_pkg::ONE_Q30 - ((34'(p_xx_q) + 34'(p_zz_q)) <<< 1);
    side2_d.s       = s_val;
    if (north || south) begin
      side2_d.ang_x.y = 34'(x_q);
      side2_d.ang_x.x = 34'(w_q);
    end else begin
      side2_d.ang_x.y = d_x <<< 1;
      side2_d.ang_x.x = qte_pkg::ONE_Q30 - ((34'(p_yy_q) + 34'(p_zz_q)) <<< 1);
    end
    if (north) begin
      side2_d.pole = qte_pkg::POLE_NORTH;
    end else if (south) begin
      side2_d.pole = qte_pkg::POLE_SOUTH;
    end else begin
      side2_d.pole = qte_pkg::POLE_NONE;
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p_xy_q <= in_data_i.quat_x * in_data_i.quat_y;
      p_zw_q <= in_data_i.quat_z * in_data_i.quat_w;
      p_yw_q <= in_data_i.quat_y * in_data_i.quat_w;
      p_xz_q <= in_data_i.quat_x * in_data_i.quat_z;
      p_yy_q <= in_data_i.quat_y * in_data_i.quat_y;
      p_zz_q <= in_data_i.quat_z * in_data_i.quat_z;
      p_xw_q <= in_data_i.quat_x * in_data_i.quat_w;
      p_yz_q <= in_data_i.quat_y * in_data_i.quat_z;
      p_xx_q <= in_data_i.quat_x * in_data_i.quat_x;
      w_q    <= in_data_i.quat_w;
      x_q    <= in_data_i.quat_x;
    end
  end

  // stages 2 to 4: sums, square of the sine term, radicand
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      side2_q <= side2_d;
      mag_q   <= mag[30:0];
      ok2_q   <= (mag[OPW-1:31] == '0);
    end
    if (rdy[2]) begin
      side3_q <= side2_q;
      sq_q    <= mag_q * mag_q;
      ok3_q   <= ok2_q;
    end
    if (rdy[3]) begin
      side4_q <= side3_q;
      rad_q   <= (ok3_q && (sq_q < qte_pkg::ONE_Q60)) ? qte_pkg::ONE_Q60 - sq_q : '0;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];
  assign out_side_o  = side4_q;
  assign out_rad_o   = rad_q;

endmodule

FILE: hw/rtl/qte_sqrt.sv
`timescale 1ns / 1ps
// pipelined floor integer square root, one root bit per stage
// depends on qte_pkg

module qte_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [qte_pkg::RAD_W-1:0]     rad_i,
  input  qte_pkg::side_t                side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [qte_pkg::SQ_STEPS-1:0]  root_o,
  output qte_pkg::side_t                side_o
);

  localparam int N      = qte_pkg::SQ_STEPS;
  localparam int RAD_W  = qte_pkg::RAD_W;
  localparam int ROOT_W = N;
  localparam int REM_W  = N + 2;
  localparam int CUR_W  = REM_W + 2;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one restoring step on the next bit pair
  function automatic sq_t sq_step(input sq_t s);
    logic [CUR_W-1:0] cur;
    logic [CUR_W-1:0] trial;
    logic [CUR_W-1:0] diff;
    sq_t r;
    cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = CUR_W'({s.root, 2'b01});
    diff  = cur - trial;
    r.rad = s.rad << 2;
    if (cur >= trial) begin
      r.rem  = diff[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [N-1:0]   v_q;
  logic [N:0]     rdy;
  sq_t            st_q [N];
  sq_t            st_d [N];
  qte_pkg::side_t sd_q [N];

  always_comb begin
    rdy[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  // next state of every stage
  always_comb begin
    st_d[0] = sq_step('{rad: rad_i, rem: '0, root: '0});
    for (int k = 1; k < N; k++) begin
      st_d[k] = sq_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      st_q[0] <= st_d[0];
      sd_q[0] <= side_i;
    end
    for (int k = 1; k < N; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];
  assign root_o      = st_q[N-1].root;
  assign side_o      = sd_q[N-1];

endmodule

FILE: hw/rtl/qte_cordic.sv
`timescale 1ns / 1ps
// vectoring cordic, three parallel atan2 lanes, a fold then one rotation per stage
// depends on qte_pkg

module qte_cordic #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  qte_pkg::vec_t [qte_pkg::LANES-1:0] lanes_i,
  input  qte_pkg::pole_e                   pole_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output qte_pkg::ang_t [qte_pkg::LANES-1:0] acc_o,
  output qte_pkg::pole_e                   pole_o
);

  localparam int NS = CORDIC_STAGES + 1;
  localparam int L  = qte_pkg::LANES;
  localparam int CW = qte_pkg::CW;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    qte_pkg::ang_t        acc;
    logic                 zero;
  } cst_t;

  // fold the left half plane onto the right, start the angle at +-pi
  function automatic cst_t cordic_pre(input qte_pkg::vec_t v);
    logic signed [CW-1:0] xe, ye;
    cst_t r;
    xe     = CW'(v.x);
    ye     = CW'(v.y);
    r.zero = (v.x == '0) && (v.y == '0);
    if (v.x[qte_pkg::OPW-1]) begin
      r.acc = v.y[qte_pkg::OPW-1] ? -qte_pkg::PI_UNITS : qte_pkg::PI_UNITS;
      r.x   = -xe;
      r.y   = -ye;
    end else begin
      r.acc = '0;
      r.x   = xe;
      r.y   = ye;
    end
    return r;
  endfunction

  // one micro-rotation, y of zero rotates as positive
  function automatic cst_t cordic_iter(input cst_t s, input int i);
    logic signed [CW-1:0] dx, dy;
    qte_pkg::ang_t t;
    cst_t r;
    dx = s.y >>> i;
    dy = s.x >>> i;
    t  = qte_pkg::atan_units(i);
    r  = s;
    if (!s.y[CW-1]) begin
      r.x   = s.x + dx;
      r.y   = s.y - dy;
      r.acc = s.acc + t;
    end else begin
      r.x   = s.x - dx;
      r.y   = s.y + dy;
      r.acc = s.acc - t;
    end
    return r;
  endfunction

  logic [NS-1:0]  v_q;
  logic [NS:0]    rdy;
  cst_t           st_q [NS][L];
  cst_t           st_d [NS][L];
  qte_pkg::pole_e pole_q [NS];

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  // stage 0 folds, stage k applies rotation k-1
  always_comb begin
    for (int l = 0; l < L; l++) begin
      st_d[0][l] = cordic_pre(lanes_i[l]);
      for (int k = 1; k < NS; k++) begin
        st_d[k][l] = cordic_iter(st_q[k-1][l], k - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pole_q[0] <= pole_i;
      for (int l = 0; l < L; l++) st_q[0][l] <= st_d[0][l];
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        pole_q[k] <= pole_q[k-1];
        for (int l = 0; l < L; l++) st_q[k][l] <= st_d[k][l];
      end
    end
  end

  // atan2 of zero over zero is zero
  always_comb begin
    for (int l = 0; l < L; l++) begin
      acc_o[l] = st_q[NS-1][l].zero ? '0 : st_q[NS-1][l].acc;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign pole_o      = pole_q[NS-1];

endmodule

FILE: hw/rtl/qte_checker.sv
`timescale 1ns / 1ps
// port-level checks for the quaternion to euler converter, bound to the top level
// depends on qte_pkg and quaternion_to_euler

module qte_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input qte_pkg::euler_t out_data_o
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // north pole gives fixed second and third angles
  a_north: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pole_case == qte_pkg::POLE_NORTH |->
      out_data_o.angle_y == '0 && out_data_o.angle_z == qte_pkg::HALF_PI_Q12)
    else $error("bad north pole angles");

  // south pole gives fixed second and third angles
  a_south: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pole_case == qte_pkg::POLE_SOUTH |->
      out_data_o.angle_y == '0 && out_data_o.angle_z == -qte_pkg::HALF_PI_Q12)
    else $error("bad south pole angles");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
